/* hdl/pcx_rle_palette_decoder_macros.svh */
// Assertion macros for the PCX run-length decoder.
`ifndef PCX_RLE_PALETTE_DECODER_MACROS_SVH
`define PCX_RLE_PALETTE_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define PCX_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked out of reset.
`define PCX_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PCX_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define PCX_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

/* hdl/pcx_pkg.sv */
package pcx_pkg;

  localparam int PIX_CNT_W = 25;
  localparam int BYTE_W = 8;
  localparam int RGB_W = 24;
  localparam int RUN_W = 6;

  localparam longint unsigned MAX_PIXELS_DEF = 64'd16777216;
  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int CMDQ_DEPTH_DEF = 4;

  localparam logic [BYTE_W-1:0] RUN_MARK = 8'hc0;
  localparam logic [BYTE_W-1:0] RUN_COUNT_MASK = 8'h3f;

  // Register indexes as decoded from paddr[2].
  localparam logic REG_PIXEL_TOTAL = 1'b0;
  localparam logic REG_PALETTE_ENABLE = 1'b1;

  localparam logic [PIX_CNT_W-1:0] PIXEL_TOTAL_RST = 25'd1;

  typedef enum logic {
    CMD_DATA,
    CMD_PAL
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic                  prefix;
    logic [BYTE_W-1:0]     code;
    logic [RGB_W-1:0]      rgb;
  } cmd_t;

  typedef struct packed {
    logic [PIX_CNT_W-1:0]  pixel_total;
    logic                  palette_enable;
  } cfg_t;

endpackage

/* hdl/pcx_rle_palette_decoder.sv */
// PCX 8-bit run-length decoder with palette lookup. Input beats carry either
// a palette entry write (tuser high) or one encoded byte (tuser low); output
// beats carry one pixel each, tlast on the final pixel of an input byte and
// tuser on the pixel that completes the image. The front end takes one beat
// per cycle into a short command queue while it has room; the back-end
// sequencer sets the rate: a palette write or run prefix ends at its pop,
// a literal byte pops with its palette read, then gives its pixel, and a run
// byte pops, then gives its pixels, up to 63. The palette needs no clearing
// pass after reset; entries that were never written read back unknown.
// Program pixel_total and palette_enable only while the decoder is idle.
`include "pcx_rle_palette_decoder_macros.svh"

module pcx_rle_palette_decoder #(
  parameter longint unsigned MAX_PIXELS      = pcx_pkg::MAX_PIXELS_DEF,
  parameter int              PALETTE_ENTRIES = pcx_pkg::PALETTE_ENTRIES_DEF,
  parameter int              CMDQ_DEPTH      = pcx_pkg::CMDQ_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // data_byte, entry_index, entry_red, entry_green, entry_blue
  input  logic        s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // pixel_byte0, pixel_byte1, pixel_byte2
  output logic        m_tlast,   // run_last
  output logic        m_tuser,   // image_done
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  pcx_pkg::cfg_t cfg;
  pcx_pkg::cmd_t front_cmd;
  pcx_pkg::cmd_t back_cmd;
  logic          front_valid;
  logic          front_ready;
  logic          back_valid;
  logic          back_ready;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_total    <= pcx_pkg::PIXEL_TOTAL_RST;
      cfg.palette_enable <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        pcx_pkg::REG_PIXEL_TOTAL:    cfg.pixel_total    <= pwdata[pcx_pkg::PIX_CNT_W-1:0];
        pcx_pkg::REG_PALETTE_ENABLE: cfg.palette_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      pcx_pkg::REG_PIXEL_TOTAL:    prdata = 32'(cfg.pixel_total);
      pcx_pkg::REG_PALETTE_ENABLE: prdata = 32'(cfg.palette_enable);
      default:                     prdata = '0;
    endcase
  end

  pcx_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  pcx_cmdq #(
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_cmd)
  );

  pcx_back #(
    .MAX_PIXELS      (MAX_PIXELS),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd       (back_cmd),
    .cfg       (cfg),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  // The pixel that completes the image always closes its run.
  `PCX_ASSERT_NOW(a_done_is_last, clk, rst, m_tvalid && m_tuser, m_tlast, "image end inside a run")
  // A run streams with no gaps once its first pixel is taken.
  `PCX_ASSERT_NEXT(a_run_gapless, clk, rst, m_tvalid && m_tready && !m_tlast, m_tvalid, "gap in run")
  // The back end takes no command while a run is still being emitted.
  `PCX_ASSERT_NOW(a_idle_between, clk, rst, back_ready && m_tvalid, m_tlast, "command taken mid-run")

endmodule

/* hdl/pcx_front.sv */
module pcx_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [39:0]   s_tdata,   // data_byte, entry_index, entry_red, entry_green, entry_blue
  input  logic          s_tuser,   // func
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output pcx_pkg::cmd_t cmd
);

  pcx_pkg::cmd_t cmd_next;
  logic [pcx_pkg::BYTE_W-1:0] data_byte;

  assign data_byte = s_tdata[7:0];

  // palette word is red, green, blue from the top down, so blue lands in pixel byte 0
  always_comb begin
    cmd_next.kind   = s_tuser ? pcx_pkg::CMD_PAL : pcx_pkg::CMD_DATA;
    cmd_next.prefix = (data_byte & pcx_pkg::RUN_MARK) == pcx_pkg::RUN_MARK;
    cmd_next.code   = s_tuser ? s_tdata[15:8] : data_byte;
    cmd_next.rgb    = {s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]};
  end

  assign s_tready = !cmd_valid || cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (s_tready) begin
      cmd_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      cmd <= cmd_next;
    end
  end

endmodule

/* hdl/pcx_cmdq.sv */
module pcx_cmdq #(
  parameter int DEPTH = pcx_pkg::CMDQ_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  pcx_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output pcx_pkg::cmd_t pop_data
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  pcx_pkg::cmd_t       slots [DEPTH];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;
  logic                push;
  logic                pop;

  assign push_ready = count != FullCnt;
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

/* hdl/pcx_back.sv */
module pcx_back #(
  parameter longint unsigned MAX_PIXELS      = pcx_pkg::MAX_PIXELS_DEF,
  parameter int              PALETTE_ENTRIES = pcx_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  pcx_pkg::cmd_t cmd,
  input  pcx_pkg::cfg_t cfg,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [23:0]   m_tdata,   // pixel_byte0, pixel_byte1, pixel_byte2
  output logic          m_tlast,   // run_last
  output logic          m_tuser    // image_done
);

  localparam int CW = pcx_pkg::PIX_CNT_W;
  localparam int RW = pcx_pkg::RUN_W;
  localparam int AW = $clog2(PALETTE_ENTRIES);
  localparam logic [CW-1:0] TotalCap =
    (MAX_PIXELS >= (64'd1 << CW)) ? {CW{1'b1}} : CW'(MAX_PIXELS);
  localparam logic [pcx_pkg::BYTE_W:0] PalLimit = (pcx_pkg::BYTE_W + 1)'(PALETTE_ENTRIES);

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  state_t                          state;
  logic                            run_pending;
  logic [RW-1:0]                   run_length;
  logic [CW-1:0]                   pixels_done;
  logic [CW-1:0]                   total_q;
  logic [RW-1:0]                   remain;
  logic [pcx_pkg::BYTE_W-1:0]      pix_idx;
  logic                            pix_in_range;
  logic [pcx_pkg::RGB_W-1:0]       pal_q;
  logic [pcx_pkg::RGB_W-1:0]       pal_mem [PALETTE_ENTRIES];

  logic [CW-1:0]                   total;
  logic                            done_ge;
  logic [CW-1:0]                   room;
  logic [RW-1:0]                   count;
  logic [RW-1:0]                   n;
  logic                            pop;
  logic                            in_range;
  logic                            out_load;
  logic [CW-1:0]                   pix_next;
  logic [pcx_pkg::RGB_W-1:0]       pix_word;
  logic [AW-1:0]                   addr;

  always_comb begin
    total    = (cfg.pixel_total > TotalCap) ? TotalCap : cfg.pixel_total;
    done_ge  = pixels_done >= total;
    room     = total - pixels_done;
    count    = run_pending ? run_length : RW'(1);
    n        = (room < CW'(count)) ? room[RW-1:0] : count;
    in_range = {1'b0, cmd.code} < PalLimit;
    addr     = cmd.code[AW-1:0];
    pix_next = pixels_done + 1'b1;
    if (cfg.palette_enable) begin
      pix_word = pix_in_range ? pal_q : '0;
    end else begin
      pix_word = {16'h0000, pix_idx};
    end
  end

  assign cmd_ready = state == S_IDLE;
  assign pop       = cmd_valid && cmd_ready;
  assign out_load  = (state == S_EMIT) && (!m_tvalid || m_tready);

  // Palette: one write port, registered read issued whenever a command leaves the queue.
  always_ff @(posedge clk) begin
    if (pop && cmd.kind == pcx_pkg::CMD_PAL && in_range) begin
      pal_mem[addr] <= cmd.rgb;
    end
    if (pop) begin
      pal_q <= pal_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      run_pending <= 1'b0;
      run_length  <= '0;
      pixels_done <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop && cmd.kind == pcx_pkg::CMD_DATA) begin
            priority if (done_ge) begin
              // image complete: drop the byte and forget any prefix
              run_pending <= 1'b0;
              run_length  <= '0;
            end else if (run_pending || !cmd.prefix) begin
              run_pending  <= 1'b0;
              run_length   <= '0;
              remain       <= n;
              pix_idx      <= cmd.code;
              pix_in_range <= in_range;
              total_q      <= total;
              if (n != '0) begin
                state <= S_EMIT;
              end
            end else begin
              run_pending <= 1'b1;
              run_length  <= cmd.code[RW-1:0] & pcx_pkg::RUN_COUNT_MASK[RW-1:0];
            end
          end
        end
        S_EMIT: begin
          if (out_load) begin
            m_tdata     <= pix_word;
            m_tlast     <= remain == RW'(1);
            m_tuser     <= pix_next == total_q;
            pixels_done <= pix_next;
            remain      <= remain - 1'b1;
            if (remain == RW'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* bench/tb_pcx_rle_palette_decoder.sv */
`timescale 1ns / 1ps

module tb_pcx_rle_palette_decoder;

  localparam logic [2:0] ADDR_PIXEL_TOTAL = {pcx_pkg::REG_PIXEL_TOTAL, 2'b00};
  localparam logic [2:0] ADDR_PALETTE_ENABLE = {pcx_pkg::REG_PALETTE_ENABLE, 2'b00};
  localparam int SETTLE_CYCLES = 96;
  localparam int STALL_CYCLES = 300;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       last;
    logic       done;
  } pixel_t;

  typedef struct {
    pcx_pkg::cmd_kind_t func;
    logic [7:0] code;
    logic [7:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    bit         typed;
    bit         typed_one;
    pixel_t     typed_pix;
  } beat_t;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  addr;
    logic [31:0] val;
    beat_t       beat;
  } step_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // data_byte, entry_index, entry_red, entry_green, entry_blue
  logic        s_tuser;   // func
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // pixel_byte0, pixel_byte1, pixel_byte2
  logic        m_tlast;   // run_last
  logic        m_tuser;   // image_done
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pcx_rle_palette_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // decoder mirror: configuration, run state and palette
  logic [pcx_pkg::PIX_CNT_W-1:0] total_r;
  logic                          pal_en_r;
  logic                          run_pend;
  logic [pcx_pkg::RUN_W-1:0]     run_len;
  longint unsigned               done_cnt;
  logic [pcx_pkg::RGB_W-1:0]     palette [256];

  pixel_t made_q[$];
  pixel_t pixel_q[$];
  beat_t  feed_q[$];
  beat_t  cur_beat;
  pixel_t want;
  pixel_t got;

  bit written [256];
  bit gen_pend;
  int src_idle = 0;
  int snk_idle = 0;
  bit stall_req = 1'b0;
  int mismatches = 0;

  task automatic flag(input string msg);
    if (mismatches < MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void emit_pixels(input logic [7:0] idx, input int cnt,
                                      input longint unsigned eff);
    longint unsigned room;
    int n;
    pixel_t p;
    room = eff - done_cnt;
    n = (longint'(cnt) > room) ? int'(room) : cnt;
    if (pal_en_r) begin
      {p.b2, p.b1, p.b0} = palette[idx];
    end else begin
      p.b0 = idx;
      p.b1 = 8'h00;
      p.b2 = 8'h00;
    end
    for (int k = 0; k < n; k++) begin
      done_cnt++;
      p.last = (k == n - 1);
      p.done = (done_cnt == eff);
      made_q.push_back(p);
    end
  endfunction

  function automatic void decode_beat(input beat_t bt);
    longint unsigned eff;
    int cnt;
    made_q.delete();
    if (bt.func == pcx_pkg::CMD_PAL) begin
      palette[bt.idx] = {bt.red, bt.green, bt.blue};
      return;
    end
    eff = (longint'(total_r) > pcx_pkg::MAX_PIXELS_DEF) ? pcx_pkg::MAX_PIXELS_DEF
                                                         : longint'(total_r);
    // image complete: drop the byte and forget any prefix
    if (done_cnt >= eff) begin
      run_pend = 1'b0;
      run_len = '0;
      return;
    end
    if (run_pend) begin
      cnt = run_len;
      run_pend = 1'b0;
      run_len = '0;
      emit_pixels(bt.code, cnt, eff);
    end else if ((bt.code & pcx_pkg::RUN_MARK) == pcx_pkg::RUN_MARK) begin
      run_pend = 1'b1;
      run_len = pcx_pkg::RUN_W'(bt.code & pcx_pkg::RUN_COUNT_MASK);
    end else begin
      emit_pixels(bt.code, 1, eff);
    end
  endfunction

  function automatic pixel_t px(input logic [7:0] b0, input logic [7:0] b1,
                                input logic [7:0] b2, input logic last, input logic done);
    pixel_t p;
    p.b0 = b0;
    p.b1 = b1;
    p.b2 = b2;
    p.last = last;
    p.done = done;
    return p;
  endfunction

  // unused fields carry random junk so that they are shown to be ignored
  function automatic beat_t data_beat(input logic [7:0] code);
    beat_t bt;
    bt.func = pcx_pkg::CMD_DATA;
    bt.code = code;
    bt.idx = 8'($urandom);
    bt.red = 8'($urandom);
    bt.green = 8'($urandom);
    bt.blue = 8'($urandom);
    bt.typed = 1'b0;
    bt.typed_one = 1'b0;
    bt.typed_pix = '0;
    return bt;
  endfunction

  function automatic beat_t pal_beat(input logic [7:0] idx, input logic [7:0] red,
                                     input logic [7:0] green, input logic [7:0] blue);
    beat_t bt;
    bt = data_beat(8'($urandom));
    bt.func = pcx_pkg::CMD_PAL;
    bt.idx = idx;
    bt.red = red;
    bt.green = green;
    bt.blue = blue;
    return bt;
  endfunction

  function automatic step_t cfg_row(input logic [2:0] addr, input logic [31:0] val);
    step_t s;
    s.is_cfg = 1'b1;
    s.addr = addr;
    s.val = val;
    s.beat = data_beat(8'h00);
    return s;
  endfunction

  function automatic step_t beat_row(input beat_t bt);
    step_t s;
    s.is_cfg = 1'b0;
    s.addr = '0;
    s.val = '0;
    s.beat = bt;
    return s;
  endfunction

  function automatic step_t sure_row(input logic [7:0] code, input bit one, input pixel_t p);
    step_t s;
    s = beat_row(data_beat(code));
    s.beat.typed = 1'b1;
    s.beat.typed_one = one;
    s.beat.typed_pix = p;
    return s;
  endfunction

  function automatic void add_pal(input logic [7:0] idx);
    written[idx] = 1'b1;
    feed_q.push_back(pal_beat(idx, 8'($urandom), 8'($urandom), 8'($urandom)));
  endfunction

  // write the palette entry first if this byte will be looked up and is still blank
  function automatic void add_byte(input logic [7:0] code);
    if (pal_en_r && (gen_pend || (code & pcx_pkg::RUN_MARK) != pcx_pkg::RUN_MARK) &&
        !written[code])
      add_pal(code);
    if (gen_pend) gen_pend = 1'b0;
    else if ((code & pcx_pkg::RUN_MARK) == pcx_pkg::RUN_MARK) gen_pend = 1'b1;
    feed_q.push_back(data_beat(code));
  endfunction

  function automatic void gen_items(input int n);
    int k;
    int cnt;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 15) begin
        add_pal(8'($urandom_range(255)));
      end else if (k < 55) begin
        add_byte(8'($urandom_range(8'hbf)));
      end else if (k < 85) begin
        // mostly short runs, now and then up to the full count
        cnt = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(8);
        add_byte(pcx_pkg::RUN_MARK | 8'(cnt));
        if ($urandom_range(9) == 0) add_pal(8'($urandom_range(255)));
        add_byte(8'($urandom_range(255)));
      end else begin
        add_byte(8'($urandom_range(255)));
      end
    end
    if (gen_pend) add_byte(8'($urandom_range(255)));
  endfunction

  task automatic drain();
    while (feed_q.size() != 0 || s_tvalid || pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr[2] == pcx_pkg::REG_PIXEL_TOTAL) total_r = val[pcx_pkg::PIX_CNT_W-1:0];
    else pal_en_r = val[0];
  endtask

  initial begin : feeder
    beat_t bt;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= 1'b0;
    forever begin
      @(posedge clk);
      if (!s_tvalid || s_tready) begin
        if (feed_q.size() != 0 && $urandom_range(99) >= src_idle) begin
          bt = feed_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {bt.blue, bt.green, bt.red, bt.idx, bt.code};
          s_tuser <= bt.func;
          cur_beat <= bt;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  initial begin : sink
    int hold;
    hold = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        hold = STALL_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= snk_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        decode_beat(cur_beat);
        if (cur_beat.typed) begin
          if (cur_beat.typed_one) pixel_q.push_back(cur_beat.typed_pix);
        end else begin
          foreach (made_q[i]) pixel_q.push_back(made_q[i]);
        end
      end
      if (m_tvalid && m_tready) begin
        got = px(m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tlast, m_tuser);
        if (pixel_q.size() == 0) begin
          flag($sformatf("pixel %h with none expected", got));
        end else begin
          want = pixel_q.pop_front();
          if (got.b0 !== want.b0) flag($sformatf("byte0 %h, want %h", got.b0, want.b0));
          if (got.b1 !== want.b1) flag($sformatf("byte1 %h, want %h", got.b1, want.b1));
          if (got.b2 !== want.b2) flag($sformatf("byte2 %h, want %h", got.b2, want.b2));
          if (got.last !== want.last) flag($sformatf("tlast %b, want %b", got.last, want.last));
          if (got.done !== want.done) flag($sformatf("tuser %b, want %b", got.done, want.done));
        end
      end
    end
  end

  initial begin : watchdog
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : main
    step_t script[$];
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    total_r = pcx_pkg::PIXEL_TOTAL_RST;
    pal_en_r = 1'b0;
    run_pend = 1'b0;
    run_len = '0;
    done_cnt = 0;
    gen_pend = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    src_idle = 34;
    snk_idle = 87;

    // zero pixel count: every byte dropped, prefix forgotten
    script.push_back(cfg_row(ADDR_PIXEL_TOTAL, 32'd0));
    script.push_back(sure_row(8'h05, 1'b0, '0));
    script.push_back(sure_row(8'hc3, 1'b0, '0));
    script.push_back(sure_row(8'h07, 1'b0, '0));
    script.push_back(cfg_row(ADDR_PIXEL_TOTAL, 32'd1000));
    // literal extremes
    script.push_back(sure_row(8'h00, 1'b1, px(8'h00, 8'h00, 8'h00, 1'b1, 1'b0)));
    script.push_back(sure_row(8'hbf, 1'b1, px(8'hbf, 8'h00, 8'h00, 1'b1, 1'b0)));
    // zero-count run swallows its byte
    script.push_back(sure_row(8'hc0, 1'b0, '0));
    script.push_back(sure_row(8'hff, 1'b0, '0));
    // longest run
    script.push_back(sure_row(8'hff, 1'b0, '0));
    script.push_back(beat_row(data_beat(8'hff)));
    // palette write in the middle of a run
    script.push_back(sure_row(8'hc2, 1'b0, '0));
    script.push_back(beat_row(pal_beat(8'h12, 8'h01, 8'h02, 8'h03)));
    script.push_back(beat_row(data_beat(8'hc5)));
    script.push_back(beat_row(pal_beat(8'h00, 8'h11, 8'h22, 8'h33)));
    script.push_back(beat_row(pal_beat(8'hff, 8'hff, 8'hff, 8'hff)));
    script.push_back(beat_row(pal_beat(8'h80, 8'h00, 8'h00, 8'h00)));
    script.push_back(cfg_row(ADDR_PALETTE_ENABLE, 32'hffff_ffff));
    script.push_back(sure_row(8'h00, 1'b1, px(8'h33, 8'h22, 8'h11, 1'b1, 1'b0)));
    script.push_back(sure_row(8'h80, 1'b1, px(8'h00, 8'h00, 8'h00, 1'b1, 1'b0)));
    script.push_back(sure_row(8'hc1, 1'b0, '0));
    script.push_back(sure_row(8'hff, 1'b1, px(8'hff, 8'hff, 8'hff, 1'b1, 1'b0)));
    script.push_back(sure_row(8'hc3, 1'b0, '0));
    script.push_back(beat_row(data_beat(8'h12)));
    script.push_back(cfg_row(ADDR_PALETTE_ENABLE, 32'hffff_fffe));
    script.push_back(sure_row(8'h7f, 1'b1, px(8'h7f, 8'h00, 8'h00, 1'b1, 1'b0)));

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        drain();
        reg_write(script[i].addr, script[i].val);
      end else begin
        if (script[i].beat.func == pcx_pkg::CMD_PAL) written[script[i].beat.idx] = 1'b1;
        feed_q.push_back(script[i].beat);
      end
    end

    // raw indices, count register written with all ones (capped)
    drain();
    reg_write(ADDR_PIXEL_TOTAL, 32'hffff_ffff);
    gen_items(50);

    drain();
    reg_write(ADDR_PIXEL_TOTAL, 32'd1_000_000 + 32'($urandom_range(4_000_000)));
    reg_write(ADDR_PALETTE_ENABLE, 32'd1);
    src_idle = 87;
    snk_idle = 34;
    gen_items(50);

    // no idling; hold the output off long enough to back the input up
    drain();
    reg_write(ADDR_PIXEL_TOTAL, 32'(pcx_pkg::MAX_PIXELS_DEF));
    src_idle = 0;
    snk_idle = 0;
    gen_items(40);
    stall_req = 1'b1;

    // finish the image inside a long run, then feed bytes that must be dropped
    drain();
    reg_write(ADDR_PIXEL_TOTAL, 32'(done_cnt + 40));
    add_byte(8'hff);
    add_byte(8'h9c);
    add_byte(8'h05);
    add_byte(8'hc3);
    add_byte(8'h07);
    gen_items(10);

    drain();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/pcx_pkg.sv
hdl/pcx_front.sv
hdl/pcx_cmdq.sv
hdl/pcx_back.sv
hdl/pcx_rle_palette_decoder.sv
bench/tb_pcx_rle_palette_decoder.sv
